>>> hw/rtl/lzss_pkg.sv
// Shared types and constants for the LZSS unit decompressor.
package lzss_pkg;

    localparam int unsigned WINDOW_BYTES_DEFAULT = 16384;

    // Widths fixed by the token format and the register map.
    localparam int unsigned DIST_W   = 14;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned CALC_W   = 18;
    localparam int unsigned LENGTH_W = 24;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIAS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd2;

    // Register values after reset.
    localparam logic [1:0]          UNIT_BYTES_RESET    = 2'd1;
    localparam logic [1:0]          LENGTH_BIAS_RESET   = 2'd2;
    localparam logic [LENGTH_W-1:0] OUTPUT_LENGTH_RESET = 24'd65536;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EARLY    = 2'd1;
    localparam logic [1:0] ST_BAD_DIST = 2'd2;

    // Flag register value with only the sentinel bit left.
    localparam logic [8:0] FLAG_EMPTY = 9'h001;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_TOKLO,
        PH_TOKHI
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_TOKCHK,
        S_RD,
        S_WR,
        S_FINISH
    } state_t;

    // Commands from the sequencer to the copy address unit.
    typedef struct packed {
        logic load;
        logic step;
    } copy_cmd_t;

    // Parser state after moving on to the next flag.
    typedef struct packed {
        logic [8:0] flag;
        phase_t     phase;
        logic       lit_load;
        logic [1:0] lit;
    } flag_upd_t;

endpackage

>>> hw/rtl/lzss_unit_decompressor.sv
// Top level of the LZSS unit decompressor: parser, copy sequencer and output register.
//
// The block takes one compressed byte per input transaction and is not ready again until
// that byte is fully handled. A control, token or literal byte passes from acceptance
// through the step and finish states before the next ready. A token's high byte adds a
// distance and length check state and then, per copied byte, a history read and then the
// write-back and output load; the single read port of the history memory and the one copy
// address unit make a back reference handle its bytes one at a time. A stalled output holds
// the sequencer, since a result is loaded only when the output register is free. The history
// memory has no clearing pass after reset; the distance check keeps reads inside the bytes
// already written by the current stream.
module lzss_unit_decompressor #(
    parameter int unsigned WINDOW_BYTES = lzss_pkg::WINDOW_BYTES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            last_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            last_out,
    output logic [1:0]                      status,
    input  logic                            cfg_write,
    input  logic [lzss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzss_pkg::CFG_W-1:0]      cfg_data
);

    localparam int unsigned PtrW = $clog2(WINDOW_BYTES);
    localparam int unsigned LenW = lzss_pkg::LENGTH_W;
    localparam int unsigned CntW = lzss_pkg::COUNT_W;
    localparam int unsigned DstW = lzss_pkg::DIST_W;
    localparam int unsigned CalcW = lzss_pkg::CALC_W;
    localparam logic [PtrW-1:0]  LastPtr = PtrW'(WINDOW_BYTES - 1);
    localparam logic [CalcW-1:0] WinCalc = CalcW'(WINDOW_BYTES);

    // Configuration registers.
    logic [1:0]      ub_reg;
    logic [1:0]      bias_reg;
    logic [LenW-1:0] olen_reg;

    // Sequencer and parser state.
    lzss_pkg::state_t state_reg, state_next;
    lzss_pkg::phase_t phase_reg, phase_next;
    logic [8:0]       flag_reg, flag_next;
    logic [1:0]       lit_reg, lit_next;
    logic [7:0]       tok_low_reg, tok_low_next;
    logic [LenW-1:0]  bw_reg, bw_next;
    logic [PtrW-1:0]  wp_reg, wp_next;
    logic             finished_reg, finished_next;
    logic             emitted_reg, emitted_next;

    // Payload held while a byte is handled.
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [DstW-1:0]  dist_reg, dist_next;
    logic [CntW-1:0]  len_reg, len_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_out_reg, last_out_next;
    logic [1:0]       status_reg, status_next;

    // Datapath signals.
    logic [1:0]       unit;
    logic             out_free;
    logic             accept;
    logic [LenW-1:0]  bw_inc;
    logic             data_last;
    logic [11:0]      tok_hi12;
    logic [4:0]       len_sum;
    logic             dist_bad;
    logic [LenW-1:0]  room;
    logic [CntW-1:0]  len_clamp;
    logic [CalcW-1:0] wp_calc;
    logic [CalcW-1:0] dist_calc;
    logic [CalcW-1:0] src_calc;
    lzss_pkg::flag_upd_t adv;

    // History memory and copy unit signals.
    logic             ram_we;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    lzss_pkg::copy_cmd_t copy_cmd;
    logic [PtrW-1:0]  copy_src;
    logic             copy_last;

    function automatic lzss_pkg::flag_upd_t advance_flag(
        input logic [8:0] f,
        input logic [1:0] u
    );
        lzss_pkg::flag_upd_t r;
        logic [8:0]          shr;
        shr        = f >> 1;
        r.flag     = shr;
        r.phase    = lzss_pkg::PH_TOKLO;
        r.lit_load = 1'b0;
        r.lit      = u;
        if (shr <= lzss_pkg::FLAG_EMPTY)
        begin
            r.flag  = lzss_pkg::FLAG_EMPTY;
            r.phase = lzss_pkg::PH_CTRL;
        end
        else if (shr[0])
        begin
            r.phase    = lzss_pkg::PH_LIT;
            r.lit_load = 1'b1;
        end
        return r;
    endfunction

    lzss_hist_ram #(
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (copy_src),
        .rd_data (ram_rdata)
    );

    lzss_copy_unit #(
        .DEPTH (WINDOW_BYTES)
    ) u_copy (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (copy_cmd),
        .load_src   (PtrW'(src_calc)),
        .load_count (len_clamp),
        .src        (copy_src),
        .last_byte  (copy_last)
    );

    assign unit      = (ub_reg == 2'd0) ? 2'd1 : ub_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == lzss_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign bw_inc    = bw_reg + 1'b1;
    assign data_last = (bw_inc >= olen_reg);
    assign tok_hi12  = {byte_reg, tok_low_reg[7:4]};
    assign len_sum   = {1'b0, tok_low_reg[3:0]} + {3'b000, bias_reg};
    assign adv       = advance_flag(flag_reg, unit);

    // Back reference checks and the start address of the copy.
    assign dist_bad  = (dist_reg == '0)
                    || ({{(LenW-DstW){1'b0}}, dist_reg} > bw_reg)
                    || ({{(CalcW-DstW){1'b0}}, dist_reg} > WinCalc);
    assign room      = olen_reg - bw_reg;
    assign len_clamp = ({{(LenW-CntW){1'b0}}, len_reg} > room) ? room[CntW-1:0] : len_reg;
    assign wp_calc   = CalcW'(wp_reg);
    assign dist_calc = {{(CalcW-DstW){1'b0}}, dist_reg};
    assign src_calc  = (wp_calc >= dist_calc) ? (wp_calc - dist_calc)
                                              : (wp_calc + WinCalc - dist_calc);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        lit_next       = lit_reg;
        tok_low_next   = tok_low_reg;
        bw_next        = bw_reg;
        wp_next        = wp_reg;
        finished_next  = finished_reg;
        emitted_next   = emitted_reg;
        dist_next      = dist_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_out_next  = last_out_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_wdata      = byte_reg;
        ram_re         = 1'b0;
        copy_cmd       = '0;

        unique case (state_reg)
            lzss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    emitted_next = 1'b0;
                    state_next   = lzss_pkg::S_STEP;
                end
            end

            lzss_pkg::S_STEP:
            begin
                if (finished_reg)
                begin
                    state_next = lzss_pkg::S_FINISH;
                end
                else if (bw_reg >= olen_reg)
                begin
                    // Length already reached: the byte is dropped and closes the stream.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'd0;
                        last_out_next  = 1'b1;
                        status_next    = lzss_pkg::ST_OK;
                        emitted_next   = 1'b1;
                        finished_next  = 1'b1;
                        state_next     = lzss_pkg::S_FINISH;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        lzss_pkg::PH_CTRL:
                        begin
                            flag_next = {1'b1, byte_reg};
                            if (byte_reg[0])
                            begin
                                phase_next = lzss_pkg::PH_LIT;
                                lit_next   = unit;
                            end
                            else
                            begin
                                phase_next = lzss_pkg::PH_TOKLO;
                            end
                            state_next = lzss_pkg::S_FINISH;
                        end

                        lzss_pkg::PH_LIT:
                        begin
                            if (out_free)
                            begin
                                ram_we         = 1'b1;
                                ram_wdata      = byte_reg;
                                wp_next        = (wp_reg == LastPtr) ? '0 : wp_reg + 1'b1;
                                bw_next        = bw_inc;
                                out_valid_next = 1'b1;
                                out_byte_next  = byte_reg;
                                last_out_next  = data_last || last_reg;
                                status_next    = (last_reg && !data_last) ? lzss_pkg::ST_EARLY
                                                                          : lzss_pkg::ST_OK;
                                emitted_next   = 1'b1;
                                finished_next  = data_last;
                                if (lit_reg > 2'd1)
                                begin
                                    lit_next = lit_reg - 1'b1;
                                end
                                else
                                begin
                                    lit_next   = 2'd0;
                                    flag_next  = adv.flag;
                                    phase_next = adv.phase;
                                    if (adv.lit_load)
                                    begin
                                        lit_next = adv.lit;
                                    end
                                end
                                state_next = lzss_pkg::S_FINISH;
                            end
                        end

                        lzss_pkg::PH_TOKLO:
                        begin
                            tok_low_next = byte_reg;
                            phase_next   = lzss_pkg::PH_TOKHI;
                            state_next   = lzss_pkg::S_FINISH;
                        end

                        lzss_pkg::PH_TOKHI:
                        begin
                            dist_next  = {2'b00, tok_hi12} * {12'd0, unit};
                            len_next   = {1'b0, len_sum} * {4'd0, unit};
                            state_next = lzss_pkg::S_TOKCHK;
                        end

                        default:
                        begin
                            state_next = lzss_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            lzss_pkg::S_TOKCHK:
            begin
                if (dist_bad)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'd0;
                        last_out_next  = 1'b1;
                        status_next    = lzss_pkg::ST_BAD_DIST;
                        emitted_next   = 1'b1;
                        finished_next  = 1'b1;
                        state_next     = lzss_pkg::S_FINISH;
                    end
                end
                else if (len_clamp == '0)
                begin
                    flag_next  = adv.flag;
                    phase_next = adv.phase;
                    if (adv.lit_load)
                    begin
                        lit_next = adv.lit;
                    end
                    state_next = lzss_pkg::S_FINISH;
                end
                else
                begin
                    copy_cmd.load = 1'b1;
                    state_next    = lzss_pkg::S_RD;
                end
            end

            lzss_pkg::S_RD:
            begin
                ram_re     = 1'b1;
                state_next = lzss_pkg::S_WR;
            end

            lzss_pkg::S_WR:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata;
                    wp_next        = (wp_reg == LastPtr) ? '0 : wp_reg + 1'b1;
                    bw_next        = bw_inc;
                    copy_cmd.step  = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    emitted_next   = 1'b1;
                    finished_next  = data_last;
                    // Only the final byte of the copy can carry the early end mark.
                    last_out_next  = data_last || (last_reg && copy_last);
                    status_next    = (last_reg && copy_last && !data_last) ? lzss_pkg::ST_EARLY
                                                                         : lzss_pkg::ST_OK;
                    if (copy_last)
                    begin
                        flag_next  = adv.flag;
                        phase_next = adv.phase;
                        if (adv.lit_load)
                        begin
                            lit_next = adv.lit;
                        end
                        state_next = lzss_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = lzss_pkg::S_RD;
                    end
                end
            end

            lzss_pkg::S_FINISH:
            begin
                if (last_reg && !finished_reg && !emitted_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'd0;
                        last_out_next  = 1'b1;
                        status_next    = lzss_pkg::ST_EARLY;
                        emitted_next   = 1'b1;
                    end
                end
                else
                begin
                    if (last_reg)
                    begin
                        flag_next     = lzss_pkg::FLAG_EMPTY;
                        phase_next    = lzss_pkg::PH_CTRL;
                        lit_next      = 2'd0;
                        tok_low_next  = 8'd0;
                        bw_next       = '0;
                        finished_next = 1'b0;
                    end
                    state_next = lzss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lzss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ub_reg        <= lzss_pkg::UNIT_BYTES_RESET;
            bias_reg      <= lzss_pkg::LENGTH_BIAS_RESET;
            olen_reg      <= lzss_pkg::OUTPUT_LENGTH_RESET;
            state_reg     <= lzss_pkg::S_IDLE;
            phase_reg     <= lzss_pkg::PH_CTRL;
            flag_reg      <= lzss_pkg::FLAG_EMPTY;
            lit_reg       <= 2'd0;
            tok_low_reg   <= 8'd0;
            bw_reg        <= '0;
            wp_reg        <= '0;
            finished_reg  <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    lzss_pkg::CFG_UNIT_BYTES:    ub_reg   <= cfg_data[1:0];
                    lzss_pkg::CFG_LENGTH_BIAS:   bias_reg <= cfg_data[1:0];
                    lzss_pkg::CFG_OUTPUT_LENGTH: olen_reg <= cfg_data[LenW-1:0];
                    default:                     ;
                endcase
            end
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            lit_reg       <= lit_next;
            tok_low_reg   <= tok_low_next;
            bw_reg        <= bw_next;
            wp_reg        <= wp_next;
            finished_reg  <= finished_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            last_reg <= last_in;
        end
        dist_reg     <= dist_next;
        len_reg      <= len_next;
        out_byte_reg <= out_byte_next;
        last_out_reg <= last_out_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_out  = last_out_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // Any result with an error or early end status closes the stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lzss_pkg::ST_OK) || last_out)
    else $error("error status without last_out");

    // Only the three defined status codes are ever presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lzss_pkg::ST_OK) || (status == lzss_pkg::ST_EARLY)
                      || (status == lzss_pkg::ST_BAD_DIST))
    else $error("undefined status code");

    // An accepted transaction always starts decoding on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == lzss_pkg::S_STEP))
    else $error("accepted byte not decoded");

    // A copy is never started with a zero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        copy_cmd.load |-> (len_clamp != '0))
    else $error("copy loaded with zero length");
`endif

endmodule

>>> hw/rtl/lzss_hist_ram.sv
// History window memory: one write port and one registered read port.
module lzss_hist_ram #(
    parameter int unsigned DEPTH = lzss_pkg::WINDOW_BYTES_DEFAULT,
    localparam int unsigned AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/lzss_copy_unit.sv
// Copy address unit: steps the source pointer and remaining count of a back reference.
module lzss_copy_unit #(
    parameter int unsigned DEPTH = lzss_pkg::WINDOW_BYTES_DEFAULT,
    localparam int unsigned AddrW = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lzss_pkg::copy_cmd_t             cmd,
    input  logic [AddrW-1:0]                load_src,
    input  logic [lzss_pkg::COUNT_W-1:0]    load_count,
    output logic [AddrW-1:0]                src,
    output logic                            last_byte
);

    localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

    logic [AddrW-1:0]             src_reg;
    logic [AddrW-1:0]             src_next;
    logic [lzss_pkg::COUNT_W-1:0] count_reg;
    logic [lzss_pkg::COUNT_W-1:0] count_next;

    always_comb
    begin
        src_next   = src_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            src_next   = load_src;
            count_next = load_count;
        end
        else if (cmd.step)
        begin
            src_next   = (src_reg == LastAddr) ? '0 : src_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
    end

    assign src       = src_reg;
    assign last_byte = (count_reg == lzss_pkg::COUNT_W'(1));

endmodule
